// ----- hdl/sha_pkg.sv -----
// ============================================================================
// sha_pkg
// Shared constants, round helpers and the controller-to-datapath command
// bundle for the SHA-256 byte-stream hash engine.
// ============================================================================
package sha_pkg;

    localparam int WORD_W     = 32;
    localparam int FILL_W     = 6;
    localparam int ROUND_W    = 6;
    localparam int LEN_W      = 64;
    localparam int DIGEST_W   = 64;
    localparam int IDX_W      = 2;
    localparam int WIN_DEPTH  = 16;

    localparam logic [7:0]        PAD_MARK   = 8'h80;
    localparam logic [FILL_W-1:0] LEN_OFFSET = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [IDX_W-1:0]  IDX_LAST   = 2'd3;

    // Command bundle from controller to datapath
    typedef struct packed {
        logic                 shift_byte;  // shift one byte into the block window
        logic                 use_pad;     // byte comes from the padding generator
        logic                 mark_done;   // 0x80 already placed
        logic                 len_ok;      // current block carries the length
        logic                 load_work;   // copy chain words into working vars
        logic                 round_step;  // run one compression round
        logic [ROUND_W-1:0]   round_idx;
        logic                 chain_add;   // fold working vars into chain
        logic                 chain_init;  // reload initial hash values
        logic                 msg_clear;   // zero the length counter
        logic [IDX_W-1:0]     out_idx;     // digest word being shown
    } sha_cmd_t;

    // Rotate right by a constant amount
    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int r);
        ror = (x >> r) | (x << (WORD_W - r));
    endfunction

    // Initial hash values
    function automatic logic [WORD_W-1:0] sha_iv(input logic [2:0] i);
        case (i)
            3'd0:    sha_iv = 32'h6a09e667;
            3'd1:    sha_iv = 32'hbb67ae85;
            3'd2:    sha_iv = 32'h3c6ef372;
            3'd3:    sha_iv = 32'ha54ff53a;
            3'd4:    sha_iv = 32'h510e527f;
            3'd5:    sha_iv = 32'h9b05688c;
            3'd6:    sha_iv = 32'h1f83d9ab;
            default: sha_iv = 32'h5be0cd19;
        endcase
    endfunction

    // Round constants
    function automatic logic [WORD_W-1:0] sha_k(input logic [ROUND_W-1:0] i);
        case (i)
            6'd0:  sha_k = 32'h428a2f98;  6'd1:  sha_k = 32'h71374491;
            6'd2:  sha_k = 32'hb5c0fbcf;  6'd3:  sha_k = 32'he9b5dba5;
            6'd4:  sha_k = 32'h3956c25b;  6'd5:  sha_k = 32'h59f111f1;
            6'd6:  sha_k = 32'h923f82a4;  6'd7:  sha_k = 32'hab1c5ed5;
            6'd8:  sha_k = 32'hd807aa98;  6'd9:  sha_k = 32'h12835b01;
            6'd10: sha_k = 32'h243185be;  6'd11: sha_k = 32'h550c7dc3;
            6'd12: sha_k = 32'h72be5d74;  6'd13: sha_k = 32'h80deb1fe;
            6'd14: sha_k = 32'h9bdc06a7;  6'd15: sha_k = 32'hc19bf174;
            6'd16: sha_k = 32'he49b69c1;  6'd17: sha_k = 32'hefbe4786;
            6'd18: sha_k = 32'h0fc19dc6;  6'd19: sha_k = 32'h240ca1cc;
            6'd20: sha_k = 32'h2de92c6f;  6'd21: sha_k = 32'h4a7484aa;
            6'd22: sha_k = 32'h5cb0a9dc;  6'd23: sha_k = 32'h76f988da;
            6'd24: sha_k = 32'h983e5152;  6'd25: sha_k = 32'ha831c66d;
            6'd26: sha_k = 32'hb00327c8;  6'd27: sha_k = 32'hbf597fc7;
            6'd28: sha_k = 32'hc6e00bf3;  6'd29: sha_k = 32'hd5a79147;
            6'd30: sha_k = 32'h06ca6351;  6'd31: sha_k = 32'h14292967;
            6'd32: sha_k = 32'h27b70a85;  6'd33: sha_k = 32'h2e1b2138;
            6'd34: sha_k = 32'h4d2c6dfc;  6'd35: sha_k = 32'h53380d13;
            6'd36: sha_k = 32'h650a7354;  6'd37: sha_k = 32'h766a0abb;
            6'd38: sha_k = 32'h81c2c92e;  6'd39: sha_k = 32'h92722c85;
            6'd40: sha_k = 32'ha2bfe8a1;  6'd41: sha_k = 32'ha81a664b;
            6'd42: sha_k = 32'hc24b8b70;  6'd43: sha_k = 32'hc76c51a3;
            6'd44: sha_k = 32'hd192e819;  6'd45: sha_k = 32'hd6990624;
            6'd46: sha_k = 32'hf40e3585;  6'd47: sha_k = 32'h106aa070;
            6'd48: sha_k = 32'h19a4c116;  6'd49: sha_k = 32'h1e376c08;
            6'd50: sha_k = 32'h2748774c;  6'd51: sha_k = 32'h34b0bcb5;
            6'd52: sha_k = 32'h391c0cb3;  6'd53: sha_k = 32'h4ed8aa4a;
            6'd54: sha_k = 32'h5b9cca4f;  6'd55: sha_k = 32'h682e6ff3;
            6'd56: sha_k = 32'h748f82ee;  6'd57: sha_k = 32'h78a5636f;
            6'd58: sha_k = 32'h84c87814;  6'd59: sha_k = 32'h8cc70208;
            6'd60: sha_k = 32'h90befffa;  6'd61: sha_k = 32'ha4506ceb;
            6'd62: sha_k = 32'hbef9a3f7;
            default: sha_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ----- hdl/sha_ctrl.sv -----
// ============================================================================
// sha_ctrl
// Sequencer for the hash engine: byte intake, padding, 64 rounds, chain
// update and digest delivery.
// ============================================================================
module sha_ctrl
    import sha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              byte_present,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  word_index,
    output logic              last_word,
    input  logic [FILL_W-1:0] fill,
    output sha_cmd_t          cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               ret_pad_reg, ret_pad_next;
    logic               final_reg, final_next;
    logic               mark_reg, mark_next;
    logic               len_ok_reg, len_ok_next;
    logic               in_xfer;
    logic               out_xfer;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == IDX_LAST);
    assign in_xfer    = in_valid && !in_stall;
    assign out_xfer   = out_valid && !out_stall;

    // Next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        ret_pad_next = ret_pad_reg;
        final_next   = final_reg;
        mark_next    = mark_reg;
        len_ok_next  = len_ok_reg;
        cmd            = '0;
        cmd.use_pad    = (state_reg == S_PAD);
        cmd.mark_done  = mark_reg;
        cmd.len_ok     = len_ok_reg;
        cmd.round_idx  = round_reg;
        cmd.out_idx    = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (end_of_message)
                    begin
                        mark_next   = 1'b0;
                        len_ok_next = 1'b0;
                        final_next  = 1'b0;
                    end
                    if (byte_present)
                    begin
                        cmd.shift_byte = 1'b1;
                        if (fill == FILL_LAST)
                        begin
                            cmd.load_work = 1'b1;
                            ret_pad_next  = end_of_message;
                            final_next    = 1'b0;
                            state_next    = S_ROUND;
                        end
                        else if (end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                // One padding byte per cycle: mark, zeros, then length
                cmd.shift_byte = 1'b1;
                mark_next      = 1'b1;
                if (!mark_reg && fill < LEN_OFFSET)
                begin
                    len_ok_next = 1'b1;
                end
                if (fill == FILL_LAST)
                begin
                    cmd.load_work = 1'b1;
                    ret_pad_next  = 1'b1;
                    final_next    = mark_reg && len_ok_reg;
                    len_ok_next   = 1'b1;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                round_next     = round_reg + 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.chain_add = 1'b1;
                if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else if (ret_pad_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        cmd.chain_init = 1'b1;
                        cmd.msg_clear  = 1'b1;
                        final_next     = 1'b0;
                        ret_pad_next   = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            round_reg   <= '0;
            idx_reg     <= '0;
            ret_pad_reg <= 1'b0;
            final_reg   <= 1'b0;
            mark_reg    <= 1'b0;
            len_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            idx_reg     <= idx_next;
            ret_pad_reg <= ret_pad_next;
            final_reg   <= final_next;
            mark_reg    <= mark_next;
            len_ok_reg  <= len_ok_next;
        end
    end

endmodule

// ----- hdl/sha_datapath.sv -----
// ============================================================================
// sha_datapath
// Block window, message schedule, one-round compression unit, chaining
// words and byte counters.
// ============================================================================
module sha_datapath
    import sha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  sha_cmd_t            cmd,
    output logic [FILL_W-1:0]   fill,
    output logic [DIGEST_W-1:0] digest_word
);

    logic [WORD_W-1:0] win_reg   [WIN_DEPTH];
    logic [WORD_W-1:0] chain_reg [8];
    logic [WORD_W-1:0] work_reg  [8];
    logic [FILL_W-1:0] fill_reg;
    logic [LEN_W-1:0]  msg_reg;

    logic [LEN_W-1:0]  len_bits;
    logic [LEN_W-1:0]  len_shift;
    logic [7:0]        pad_byte;
    logic [7:0]        byte_in;
    logic [WORD_W-1:0] w_new;
    logic [WORD_W-1:0] sig0, sig1;
    logic [WORD_W-1:0] big0, big1, pick, vote, t1, t2;

    assign fill = fill_reg;

    // Padding byte: mark, then zeros, length bytes in the last eight slots
    assign len_bits  = {msg_reg[LEN_W-4:0], 3'b000};
    assign len_shift = len_bits >> {~fill_reg[2:0], 3'b000};
    always_comb
    begin
        if (!cmd.mark_done)
        begin
            pad_byte = PAD_MARK;
        end
        else if (cmd.len_ok && fill_reg >= LEN_OFFSET)
        begin
            pad_byte = len_shift[7:0];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end
    assign byte_in = cmd.use_pad ? pad_byte : data_byte;

    // Message schedule
    assign sig0  = ror(win_reg[1], 7) ^ ror(win_reg[1], 18) ^ (win_reg[1] >> 3);
    assign sig1  = ror(win_reg[14], 17) ^ ror(win_reg[14], 19) ^ (win_reg[14] >> 10);
    assign w_new = win_reg[0] + sig0 + win_reg[9] + sig1;

    // Round function
    assign big1 = ror(work_reg[4], 6) ^ ror(work_reg[4], 11) ^ ror(work_reg[4], 25);
    assign pick = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign t1   = work_reg[7] + big1 + pick + sha_k(cmd.round_idx) + win_reg[0];
    assign big0 = ror(work_reg[0], 2) ^ ror(work_reg[0], 13) ^ ror(work_reg[0], 22);
    assign vote = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                ^ (work_reg[1] & work_reg[2]);
    assign t2   = big0 + vote;

    // Block window: byte shifts during intake, word shifts during rounds
    always_ff @(posedge clk)
    begin
        if (cmd.shift_byte)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= {win_reg[i][WORD_W-9:0], win_reg[i+1][WORD_W-1:WORD_W-8]};
            end
            win_reg[WIN_DEPTH-1] <= {win_reg[WIN_DEPTH-1][WORD_W-9:0], byte_in};
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_DEPTH-1] <= w_new;
        end
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    // Chaining words and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_iv(3'(i));
            end
            fill_reg <= '0;
            msg_reg  <= '0;
        end
        else
        begin
            if (cmd.chain_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= sha_iv(3'(i));
                end
            end
            else if (cmd.chain_add)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (cmd.shift_byte)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.msg_clear)
            begin
                msg_reg <= '0;
            end
            else if (cmd.shift_byte && !cmd.use_pad)
            begin
                msg_reg <= msg_reg + 1'b1;
            end
        end
    end

    // Digest word select
    always_comb
    begin
        case (cmd.out_idx)
            2'd0:    digest_word = {chain_reg[0], chain_reg[1]};
            2'd1:    digest_word = {chain_reg[2], chain_reg[3]};
            2'd2:    digest_word = {chain_reg[4], chain_reg[5]};
            default: digest_word = {chain_reg[6], chain_reg[7]};
        endcase
    end

endmodule

// ----- hdl/sha256_hash_engine_top.sv -----
// ============================================================================
// sha256_hash_engine_top
// SHA-256 engine that hashes a byte stream and returns a 256-bit digest.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) carries data_byte, byte_present and
//   end_of_message. A byte is taken per transfer; the 64th byte of a block
//   starts 64 compression rounds plus a chain update, during which
//   in_stall is high, so no new byte is taken until the block is done.
//   The stall comes from the single shared round unit.
//   An item with end_of_message starts padding: one padding byte per cycle
//   up to the end of the block, then one or two more compressions
//   before the first digest word.
//   Output channel (out_valid/out_stall) then shows the digest as four
//   64-bit big-endian words, word_index 0 first, last_word on index 3.
//   While out_stall is high the current word holds. After the last
//   transfer the engine reloads its initial hash and takes a new message.
//   Reset (rst_n low, asynchronous) loads the initial hash values, clears
//   the byte counters and returns to the ready state.
// ============================================================================
module sha256_hash_engine_top
    import sha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DIGEST_W-1:0] digest_word,
    output logic [IDX_W-1:0]    word_index,
    output logic                last_word
);

    sha_cmd_t          cmd;
    logic [FILL_W-1:0] fill;

    // Sequencer
    sha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .last_word      (last_word),
        .fill           (fill),
        .cmd            (cmd)
    );

    // Hash datapath
    sha_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .fill        (fill),
        .digest_word (digest_word)
    );

endmodule

// ----- hdl/sha_checker.sv -----
// ============================================================================
// sha_checker
// Port-level checks for the hash engine, bound to the top level.
// ============================================================================
module sha_checker
    import sha_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [DIGEST_W-1:0] digest_word,
    input logic [IDX_W-1:0]    word_index,
    input logic                last_word
);

    // No input transfer while the digest is being delivered
    a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during digest delivery");

    // Digest words step through in order
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=>
            out_valid && (word_index == $past(word_index) + 2'd1))
        else $error("digest word order broken");

    // Last word ends the digest and frees the input side
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> !out_valid && !in_stall)
        else $error("engine did not return to ready after last word");

    // Stalled digest word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(digest_word) && $stable(word_index))
        else $error("stalled digest word changed");

endmodule

bind sha256_hash_engine_top sha_checker u_sha_checker (.*);
